// ----- src/tcs_pkg.sv -----
// Package: shared constants and types for the tagged chunk store.
`default_nettype none
package tcs_pkg;
  localparam int NumChunks      = 16;
  localparam int ChunkDataBytes = 16;
  localparam int MaxRecordBytes = 100;
  localparam int ChunkW  = $clog2(NumChunks);
  localparam int CountW  = $clog2(NumChunks + 1);
  localparam int OffW    = $clog2(ChunkDataBytes);
  localparam int PoolW   = ChunkW + OffW;
  localparam int OrdW    = 3;

  localparam logic [2:0] ActBegin  = 3'd0;
  localparam logic [2:0] ActByte   = 3'd1;
  localparam logic [2:0] ActRead   = 3'd2;
  localparam logic [2:0] ActHeader = 3'd3;
  localparam logic [2:0] ActDelete = 3'd4;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StNotFound = 3'd1;
  localparam logic [2:0] StNoSpace  = 3'd2;
  localparam logic [2:0] StInvalid  = 3'd3;
  localparam logic [2:0] StIgnored  = 3'd4;

  // Tag entry: owner node and ordinal within the record
  typedef struct packed {
    logic [7:0]      owner;
    logic [OrdW-1:0] ordinal;
  } tag_t;
endpackage
`default_nettype wire

// ----- src/tcs_tag_ram.sv -----
// Tag memory: owner and ordinal per chunk, one write and one registered read port.
`default_nettype none
module tcs_tag_ram (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [tcs_pkg::ChunkW-1:0] waddr,
  input  wire tcs_pkg::tag_t             wdata,
  input  wire logic [tcs_pkg::ChunkW-1:0] raddr,
  output tcs_pkg::tag_t                  rdata
);
  tcs_pkg::tag_t mem [tcs_pkg::NumChunks];

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- src/tcs_byte_ram.sv -----
// Byte pool memory: chunk data bytes, one write and one registered read port.
`default_nettype none
module tcs_byte_ram (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [tcs_pkg::PoolW-1:0] waddr,
  input  wire logic [7:0]               wdata,
  input  wire logic [tcs_pkg::PoolW-1:0] raddr,
  output logic [7:0]                    rdata
);
  logic [7:0] mem [2**tcs_pkg::PoolW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- src/tagged_chunk_store_top.sv -----
// Top level: tagged chunk store control sequencer around tag and byte memories.
`default_nettype none
// One item per start pulse while busy is low. After reset a clearing pass
// zeroes all 256 bytes of the byte pool, and the tag memory alongside the
// first 16 of them; busy is high throughout. An item then scans the tag
// memory one chunk a cycle through its single read port, and a begin save
// takes two scans. A node-zero, undefined or out-of-range read item, or a
// byte item ignored for want of an open save, skips the scan. The result
// shows for one cycle with done high and cannot be stalled; busy is already
// low in that cycle, so the next item may be accepted at the edge that
// ends it.
module tagged_chunk_store_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] action,
  input  wire logic [7:0] node_id,
  input  wire logic [7:0] length,
  input  wire logic [7:0] data_byte,
  input  wire logic [7:0] position,
  output logic            done,
  output logic [2:0]      status,
  output logic [7:0]      read_byte,
  output logic [6:0]      count,
  output logic [4:0]      free_chunks
);
  localparam int CW = tcs_pkg::ChunkW;
  localparam int PW = tcs_pkg::PoolW;
  localparam int OW = tcs_pkg::OffW;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_ALLOC = 7'b0001000,
    S_BYTE  = 7'b0010000,
    S_WAIT  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;
  logic [PW:0]     clr;
  logic [CW:0]     idx;      // issue index
  logic            rvalid;
  logic [CW-1:0]   ridx;     // index of data now on the read port
  logic [2:0]      act;
  logic [7:0]      node;
  logic [6:0]      len;
  logic [7:0]      dbyte;
  logic [7:0]      pos;
  logic [tcs_pkg::OrdW-1:0] want;
  logic [tcs_pkg::OrdW:0]   need;
  logic [tcs_pkg::OrdW:0]   ord;
  logic            found;
  logic [CW-1:0]   hit;
  logic [tcs_pkg::CountW-1:0] free_count;
  logic            save_open;
  logic [7:0]      save_node;
  logic [6:0]      save_length;
  logic [6:0]      save_position;
  logic [2:0]      st;
  logic [6:0]      cnt;
  logic            byte_pending;

  tcs_pkg::tag_t   tag_rd, tag_wd;
  logic            tag_we;
  logic [CW-1:0]   tag_wa;
  logic            b_we;
  logic [PW-1:0]   b_wa, b_ra;
  logic [7:0]      b_wd, b_rd;

  tcs_tag_ram u_tag (.clk, .we(tag_we), .waddr(tag_wa), .wdata(tag_wd),
                     .raddr(idx[CW-1:0]), .rdata(tag_rd));
  tcs_byte_ram u_byte (.clk, .we(b_we), .waddr(b_wa), .wdata(b_wd),
                       .raddr(b_ra), .rdata(b_rd));

  logic [7:0] len_clamp;
  assign len_clamp = (length > 8'(tcs_pkg::MaxRecordBytes))
                   ? 8'(tcs_pkg::MaxRecordBytes) : length;

  // Memory write and read control
  always_comb begin
    tag_we = 1'b0;
    tag_wa = ridx;
    tag_wd = '0;
    b_we   = 1'b0;
    b_wa   = clr[PW-1:0];
    b_wd   = '0;
    b_ra   = {hit, pos[OW-1:0]};
    if (state == S_CLEAR) begin
      b_we = 1'b1;
      if (clr < (PW+1)'(tcs_pkg::NumChunks)) begin
        tag_we = 1'b1;
        tag_wa = clr[CW-1:0];
      end
    end else if (state == S_SCAN && rvalid && (act == tcs_pkg::ActBegin ||
                 act == tcs_pkg::ActDelete) && tag_rd.owner == node) begin
      tag_we = 1'b1;
    end else if (state == S_ALLOC && rvalid && tag_rd.owner == '0 &&
                 ord < need) begin
      tag_we = 1'b1;
      tag_wd.owner = node;
      tag_wd.ordinal = ord[tcs_pkg::OrdW-1:0];
    end
    if (state == S_BYTE && byte_pending) begin
      b_we = 1'b1;
      b_wa = {hit, save_position[OW-1:0]};
      b_wd = dbyte;
    end
  end

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      idx <= '0;
      rvalid <= 1'b0;
      free_count <= tcs_pkg::CountW'(tcs_pkg::NumChunks);
      save_open <= 1'b0;
      done <= 1'b0;
      byte_pending <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (PW+1)'(2**PW - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            act <= action; dbyte <= data_byte;
            node <= (action == tcs_pkg::ActByte) ? save_node : node_id;
            // header query reads the first byte of the chunk
            pos <= (action == tcs_pkg::ActHeader) ? '0 : position;
            len <= len_clamp[6:0];
            need <= (tcs_pkg::OrdW+1)'((len_clamp + 8'(tcs_pkg::ChunkDataBytes - 1))
                    >> OW);
            found <= 1'b0; cnt <= '0; ord <= '0;
            idx <= '0; rvalid <= 1'b0;
            if (action == tcs_pkg::ActByte) begin
              want <= tcs_pkg::OrdW'(save_position >> OW);
              if (save_open && save_position < save_length) begin
                st <= tcs_pkg::StOk; state <= S_SCAN;
              end else begin st <= tcs_pkg::StIgnored; state <= S_DONE; end
            end else if (action > tcs_pkg::ActDelete) begin
              st <= tcs_pkg::StIgnored; state <= S_DONE;
            end else if (node_id == '0) begin
              st <= tcs_pkg::StInvalid; state <= S_DONE;
            end else begin
              want <= (action == tcs_pkg::ActRead)
                    ? tcs_pkg::OrdW'(position >> OW) : '0;
              if (action == tcs_pkg::ActRead &&
                  position >= 8'(tcs_pkg::MaxRecordBytes)) begin
                st <= tcs_pkg::StNotFound; state <= S_DONE;
              end else begin st <= tcs_pkg::StOk; state <= S_SCAN; end
            end
          end
        end
        S_SCAN, S_ALLOC: begin
          // issue one read per cycle, evaluate the previous one
          rvalid <= !idx[CW] && idx < (CW+1)'(tcs_pkg::NumChunks);
          ridx <= idx[CW-1:0];
          if (idx < (CW+1)'(tcs_pkg::NumChunks)) idx <= idx + 1'b1;
          if (rvalid) begin
            if (state == S_SCAN) begin
              if ((act == tcs_pkg::ActBegin || act == tcs_pkg::ActDelete) &&
                  tag_rd.owner == node)
                free_count <= free_count + 1'b1;
              if (tag_rd.owner == node && tag_rd.ordinal == want && !found) begin
                found <= 1'b1; hit <= ridx;
              end
            end else if (tag_rd.owner == '0 && ord < need) begin
              ord <= ord + 1'b1;
              free_count <= free_count - 1'b1;
            end
          end
          if (!rvalid && idx == (CW+1)'(tcs_pkg::NumChunks)) begin
            idx <= '0;
            if (state == S_SCAN) begin
              unique case (act)
                tcs_pkg::ActBegin: begin
                  if ({1'b0, free_count} >= (tcs_pkg::CountW+1)'(need)) begin
                    cnt <= len; state <= S_ALLOC;
                    save_open <= (len != '0);
                    if (len != '0) begin
                      save_node <= node;
                      save_length <= len; save_position <= '0;
                    end
                  end else begin
                    save_open <= 1'b0;
                    st <= tcs_pkg::StNoSpace; state <= S_DONE;
                  end
                end
                tcs_pkg::ActDelete: begin
                  if (save_open && save_node == node) save_open <= 1'b0;
                  state <= S_DONE;
                end
                tcs_pkg::ActByte: begin
                  if (found) begin byte_pending <= 1'b1; state <= S_BYTE; end
                  else begin st <= tcs_pkg::StIgnored; state <= S_DONE; end
                end
                default: begin
                  if (found) state <= S_WAIT;
                  else begin st <= tcs_pkg::StNotFound; state <= S_DONE; end
                end
              endcase
            end else state <= S_DONE;
          end
        end
        S_BYTE: begin
          byte_pending <= 1'b0;
          save_position <= save_position + 1'b1;
          if (save_position + 1'b1 >= save_length) save_open <= 1'b0;
          state <= S_DONE;
        end
        S_WAIT: begin
          // byte read address settles, data arrives next cycle
          idx <= (CW+1)'(tcs_pkg::NumChunks);
          if (rvalid) state <= S_DONE;
          rvalid <= 1'b1;
        end
        S_DONE: begin
          status <= st;
          read_byte <= (act == tcs_pkg::ActRead || act == tcs_pkg::ActHeader) &&
                       st == tcs_pkg::StOk && node != '0 ? b_rd : '0;
          count <= cnt;
          free_chunks <= 5'(free_count);
          rvalid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

`ifndef ASSERT_OFF
  a_free_range: assert property (@(posedge clk) disable iff (rst)
    free_count <= tcs_pkg::CountW'(tcs_pkg::NumChunks))
    else $error("free count above pool size");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("result strobe outside idle");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transfer accepted but block not busy");
`endif
endmodule
`default_nettype wire
